### sv/bpdc_pkg.sv
// Shared types and constants of the button press duration classifier.
`timescale 1ns / 1ps

package bpdc_pkg;

  // Channels covered by the registers and the pin field.
  localparam int HwChannels = 4;
  localparam int DefaultNumChannels = 4;

  localparam int PinW     = 4;
  localparam int CountW   = 16;
  localparam int DelayW   = 16;
  localparam int MaskW    = 4;
  localparam int ChanIdxW = 2;
  localparam int ActionW  = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [ActionW-1:0] {
    ACT_NONE   = 2'd0,
    ACT_FIRST  = 2'd1,
    ACT_SECOND = 2'd2
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DELAY0      = 3'd0,
    REG_DELAY1      = 3'd1,
    REG_DELAY2      = 3'd2,
    REG_DELAY3      = 3'd3,
    REG_ACTIVE_HIGH = 3'd4,
    REG_ENABLE      = 3'd5
  } cfg_reg_t;

  // What one lane reports for the current tick.
  typedef struct packed {
    action_t action;
    logic    active;
  } lane_result_t;

endpackage

### sv/bpdc_in_if.sv
// Request channel that carries one timer tick with the raw pin levels.
`timescale 1ns / 1ps

interface bpdc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpdc_pkg::PinW-1:0]  pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

### sv/bpdc_out_if.sv
// Result channel that carries one per-channel classification.
`timescale 1ns / 1ps

interface bpdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpdc_pkg::ChanIdxW-1:0] chan_index;
  logic [bpdc_pkg::ActionW-1:0]  action;
  logic                          any_active;
  logic                          last;

  modport source (output valid, output chan_index, output action,
                  output any_active, output last, input ready);
  modport sink   (input valid, input chan_index, input action,
                  input any_active, input last, output ready);
endinterface

### sv/button_press_duration_classifier.sv
// Top level of the button press duration classifier.
`timescale 1ns / 1ps

// Each request on the ticks channel is one timer tick with the raw level of
// every button pin. Every channel has its own lane that adjusts the pin for
// its active level, counts active ticks in a 16-bit counter that saturates at
// 0xFFFF, and classifies presses: with a zero delay register the channel
// reports the first action when a press begins and the second on release;
// with a nonzero delay only the release reports, the first action for a press
// no longer than the delay and the second otherwise. All lanes work on the
// same tick in the cycle it is accepted. A merge stage then sends one result
// per channel in channel order, one per cycle while the results channel is
// ready, and marks the final one with last and the any-active flag. A tick
// therefore occupies the single result port for one result per channel (at
// most four), and that port sets the sustained tick rate. A tick goes from
// the holding register to the output register before its first result
// appears; the holding register takes the next tick while the results of
// the previous one are still going out. The user must make configuration
// writes only while no tick is in flight; the block itself does not enforce
// this. Disabled channels report no action and keep their counters.

module button_press_duration_classifier #(
  parameter int NUM_CHANNELS = bpdc_pkg::DefaultNumChannels
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpdc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bpdc_pkg::CfgDataW-1:0]   cfg_data,
  bpdc_in_if.sink                         ticks,
  bpdc_out_if.source                      results
);
  import bpdc_pkg::*;

  // The registers and the pin field cover only four channels.
  localparam int NumLanes = (NUM_CHANNELS < 1) ? 1 :
                            (NUM_CHANNELS > HwChannels) ? HwChannels : NUM_CHANNELS;

  logic [DelayW-1:0] delay_reg [HwChannels];
  logic [MaskW-1:0]  active_high_mask;
  logic [MaskW-1:0]  enable_mask;

  logic              take_ready;
  logic              step;
  lane_result_t      lane_res [NumLanes];

  // Register writes; indexes past the enable mask are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HwChannels; i++) begin
        delay_reg[i] <= '0;
      end
      active_high_mask <= '0;
      enable_mask      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY0:      delay_reg[0]     <= cfg_data[DelayW-1:0];
        REG_DELAY1:      delay_reg[1]     <= cfg_data[DelayW-1:0];
        REG_DELAY2:      delay_reg[2]     <= cfg_data[DelayW-1:0];
        REG_DELAY3:      delay_reg[3]     <= cfg_data[DelayW-1:0];
        REG_ACTIVE_HIGH: active_high_mask <= cfg_data[MaskW-1:0];
        REG_ENABLE:      enable_mask      <= cfg_data[MaskW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ticks.ready = take_ready;
  assign step        = ticks.valid && take_ready;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    bpdc_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .enable      (enable_mask[g]),
      .active_high (active_high_mask[g]),
      .raw         (ticks.pin_levels[g]),
      .delay       (delay_reg[g]),
      .result      (lane_res[g])
    );
  end

  bpdc_merge #(
    .NumLanes (NumLanes)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .lane_res   (lane_res),
    .take_ready (take_ready),
    .results    (results)
  );

endmodule

### sv/bpdc_lane.sv
// One channel: active-level adjust, saturating press counter and classification.
`timescale 1ns / 1ps

module bpdc_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          enable,
  input  logic                          active_high,
  input  logic                          raw,
  input  logic [bpdc_pkg::DelayW-1:0]   delay,
  output bpdc_pkg::lane_result_t        result
);
  import bpdc_pkg::*;

  logic [CountW-1:0] press_count;
  logic [CountW-1:0] press_count_next;
  logic              act;
  logic              cnt_zero;
  logic              dly_zero;
  action_t           action;

  assign act      = active_high ? raw : !raw;
  assign cnt_zero = (press_count == '0);
  assign dly_zero = (delay == '0);

  always_comb begin
    action = ACT_NONE;
    if (act) begin
      if (dly_zero && cnt_zero) begin
        action = ACT_FIRST;
      end
    end else if (!cnt_zero) begin
      if (dly_zero) begin
        action = ACT_SECOND;
      end else begin
        action = (press_count <= delay) ? ACT_FIRST : ACT_SECOND;
      end
    end
  end

  // On an accepted tick, a release leaves an enabled channel's counter at zero.
  always_comb begin
    if (!act) begin
      press_count_next = '0;
    end else if (press_count == CountMax) begin
      press_count_next = press_count;
    end else begin
      press_count_next = press_count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= '0;
    end else if (step && enable) begin
      press_count <= press_count_next;
    end
  end

  assign result.action = enable ? action : ACT_NONE;
  assign result.active = enable && act;

endmodule

### sv/bpdc_merge.sv
// Collects a tick's lane results and sends one per cycle while results is ready.
`timescale 1ns / 1ps

module bpdc_merge #(
  parameter int NumLanes = bpdc_pkg::HwChannels
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  bpdc_pkg::lane_result_t lane_res [NumLanes],
  output logic                   take_ready,
  bpdc_out_if.source             results
);
  import bpdc_pkg::*;

  localparam int IdxW = (NumLanes > 1) ? $clog2(NumLanes) : 1;

  logic              hold_valid;
  action_t           hold_action [NumLanes];
  logic              hold_any;

  logic              out_valid;
  logic [IdxW-1:0]   out_count;
  action_t           out_action [NumLanes];
  logic              out_any;

  logic              any_now;
  logic              last_now;
  logic              out_step;
  logic              out_done;
  logic              load;

  always_comb begin
    any_now = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      any_now = any_now | lane_res[i].active;
    end
  end

  assign last_now   = (out_count == IdxW'(NumLanes - 1));
  assign out_step   = out_valid && results.ready;
  assign out_done   = out_step && last_now;
  assign load       = hold_valid && (!out_valid || out_done);
  assign take_ready = !hold_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (step) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < NumLanes; i++) begin
        hold_action[i] <= lane_res[i].action;
      end
      hold_any <= any_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_count <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_count <= '0;
      end else if (out_done) begin
        out_valid <= 1'b0;
      end else if (out_step) begin
        out_count <= out_count + IdxW'(1);
      end
    end
  end

  // The head of the shift line is always the channel on the port.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NumLanes; i++) begin
        out_action[i] <= hold_action[i];
      end
      out_any <= hold_any;
    end else if (out_step) begin
      for (int i = 0; i < NumLanes - 1; i++) begin
        out_action[i] <= out_action[i + 1];
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.chan_index = ChanIdxW'(out_count);
  assign results.action     = out_action[0];
  assign results.any_active = last_now && out_any;
  assign results.last       = last_now;

endmodule

### sv/bpdc_checker.sv
// Port-level checks of the classifier and the bind that attaches them.
`timescale 1ns / 1ps

module bpdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [bpdc_pkg::ChanIdxW-1:0] res_chan_index,
  input logic [bpdc_pkg::ActionW-1:0]  res_action,
  input logic                          res_any_active,
  input logic                          res_last
);
  import bpdc_pkg::*;

  // A stalled result holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_chan_index) &&
      $stable(res_action) && $stable(res_any_active) && $stable(res_last))
    else $error("stalled result changed");

  // Results of one tick follow without gaps and in channel order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=>
      res_valid && (res_chan_index == $past(res_chan_index) + 2'd1))
    else $error("channel results out of order");

  // The any-active flag only rides on the final result.
  a_any_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !res_any_active)
    else $error("any_active on a non-final result");

  // Only the three defined action codes appear.
  a_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_action == ACT_NONE) || (res_action == ACT_FIRST) ||
      (res_action == ACT_SECOND))
    else $error("undefined action code");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_chan_index (results.chan_index),
  .res_action     (results.action),
  .res_any_active (results.any_active),
  .res_last       (results.last)
);

### bench/button_press_duration_classifier_test.sv
// Self-checking testbench for the button press duration classifier.
`timescale 1ns / 1ps

// The bench drives timer ticks into the classifier over the tick request
// channel and collects per-channel results from the result channel. A small
// scoreboard class keeps its own copy of the configuration registers and the
// press counters. For every accepted tick it works out the result of each
// channel and queues it. Every accepted result is then checked field by field
// against the oldest queued one.
//
// The run goes through these parts:
//   - ticks with the reset configuration, where every channel is disabled;
//   - a directed press script with mixed active levels and delays of zero,
//     one, three and 0xFFFF. It covers press and release reporting, short and
//     long presses, and releases that land exactly on the threshold;
//   - a second script with some channels disabled, one of them halfway
//     through a press. It also writes the two unused register indexes, and
//     mask data whose upper bits are set;
//   - several random phases, each with its own configuration. In these, pins
//     mostly follow per-channel press and release runs of random length, and
//     the rest is noise.
// Configuration is written only after every queued result has come back.
// Both the tick sender and the result receiver stall at random. Some
// stretches run with no stalls at all.

module button_press_duration_classifier_test;
  import bpdc_pkg::*;

  localparam int NumChannels = DefaultNumChannels;

  // The register file decodes three index bits but only six registers exist.
  // Writes to the two spare indexes must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareB = 3'd7;

  localparam int RandomPhases = 6;
  localparam int PhaseTicks   = 76;
  // Settling time after the last result. It covers the holding and output
  // registers of the merge stage.
  localparam int SettleCycles = 8;
  localparam int ResetCycles  = 12;
  // The slowest correct run is well under one millisecond. This gives
  // several times that.
  localparam int unsigned LimitNs = 4_000_000;

  // Pin levels of the first directed script. Channels 0 and 2 are active
  // high and channels 1 and 3 are active low, so 4'b1010 is all idle and
  // 4'b0101 is all pressed.
  localparam logic [PinW-1:0] PressScript [14] = '{
    4'b1010, 4'b0101, 4'b1010,                    // one-tick press
    4'b0101, 4'b0101, 4'b1010,                    // two-tick press
    4'b0101, 4'b0101, 4'b0101, 4'b0101, 4'b1010,  // four-tick press
    4'b0000, 4'b1111, 4'b0000                     // all-low and all-high pins
  };

  // Pin levels of the second script. All pins are active high and only
  // channels 1 and 2 are enabled. Toggling pins 0 and 3 must not change
  // anything.
  localparam logic [PinW-1:0] MaskScript [8] = '{
    4'b0000, 4'b1111, 4'b1111, 4'b0000, 4'b1001, 4'b0110, 4'b0110, 4'b0000
  };

  // One expected result of one channel for one tick.
  typedef struct {
    logic [ChanIdxW-1:0] chan;
    action_t             action;
    logic                any_active;
    logic                last;
  } lane_report_t;

  // Tracks the press counters and register contents, and predicts the
  // results of each accepted tick.
  class press_scoreboard;
    logic [DelayW-1:0] delay [HwChannels];
    logic [CountW-1:0] press_count [HwChannels];
    logic [MaskW-1:0]  active_high;
    logic [MaskW-1:0]  enable;
    lane_report_t      waiting_q[$];
    int unsigned       mismatches;
    int                lanes;

    function new(int num_channels);
      lanes = num_channels < 1 ? 1 : (num_channels > HwChannels ? HwChannels : num_channels);
      for (int c = 0; c < HwChannels; c++) begin
        delay[c] = '0;
        press_count[c] = '0;
      end
      active_high = '0;
      enable = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DELAY0, REG_DELAY1, REG_DELAY2, REG_DELAY3: begin
          delay[idx[1:0]] = data[DelayW-1:0];
        end
        REG_ACTIVE_HIGH: begin
          active_high = data[MaskW-1:0];
        end
        REG_ENABLE: begin
          enable = data[MaskW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Advances every enabled channel by one tick and queues one result per
    // channel. The final one carries last and the any-active flag.
    function void note_tick(logic [PinW-1:0] pins);
      lane_report_t rep;
      logic         any_on;
      logic         pressed;
      logic [CountW-1:0] cnt;
      any_on = 1'b0;
      for (int c = 0; c < lanes; c++) begin
        rep.chan = ChanIdxW'(c);
        rep.action = ACT_NONE;
        rep.any_active = 1'b0;
        rep.last = 1'b0;
        if (enable[c]) begin
          pressed = active_high[c] ? pins[c] : !pins[c];
          cnt = press_count[c];
          if (delay[c] == '0 && pressed && cnt == '0) rep.action = ACT_FIRST;
          if (pressed && cnt != CountMax) cnt = cnt + 1'b1;
          if (!pressed && cnt != '0) begin
            if (delay[c] == '0 || cnt > delay[c]) rep.action = ACT_SECOND;
            else rep.action = ACT_FIRST;
            cnt = '0;
          end
          press_count[c] = cnt;
          any_on |= pressed;
        end
        if (c == lanes - 1) begin
          rep.any_active = any_on;
          rep.last = 1'b1;
        end
        waiting_q.push_back(rep);
      end
    endfunction

    function void check_result(logic [ChanIdxW-1:0] chan, logic [ActionW-1:0] action,
                               logic any_active, logic last);
      lane_report_t exp;
      if (waiting_q.size() == 0) begin
        flag($sformatf("unexpected result chan=%0d action=%0d any=%0d last=%0d",
                       chan, action, any_active, last));
        return;
      end
      exp = waiting_q.pop_front();
      if (chan !== exp.chan || action !== exp.action ||
          any_active !== exp.any_active || last !== exp.last)
        flag($sformatf("expected chan=%0d action=%0d any=%0d last=%0d, got %0d/%0d/%0d/%0d",
                       exp.chan, exp.action, exp.any_active, exp.last,
                       chan, action, any_active, last));
    endfunction

    function int outstanding();
      return waiting_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // When set, neither side stalls.
  bit steady = 1'b0;

  // Per-channel pin level and remaining run length for the random phases.
  logic [PinW-1:0] run_level;
  int unsigned run_left [HwChannels];

  bpdc_in_if  tick_bus ();
  bpdc_out_if result_bus ();

  press_scoreboard board = new(NumChannels);

  button_press_duration_classifier #(
    .NUM_CHANNELS(NumChannels)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .ticks(tick_bus),
    .results(result_bus)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stall lengths. Most are short, a few are long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Delay values for the random phases. Small values dominate so that random
  // press lengths fall on both sides of the threshold. The extremes still
  // show up now and then.
  function automatic logic [DelayW-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 85) return DelayW'($urandom_range(1, 8));
    if (r < 95) return '1;
    return DelayW'($urandom);
  endfunction

  // Both channels are sampled at the clock edge. Every signal here is driven
  // by nonblocking assignments or by logic on registers, so what is seen is the value before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_bus.valid && tick_bus.ready) board.note_tick(tick_bus.pin_levels);
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.chan_index, result_bus.action,
                           result_bus.any_active, result_bus.last);
    end
  end

  // The receiver alternates bursts of ready with stalls of random length.
  initial begin
    int unsigned stall;
    result_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      result_bus.ready <= 1'b1;
      repeat (1 + $urandom_range(0, 7)) @(posedge clk);
      stall = steady ? 0 : gap_len();
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offers one tick and holds it until it is accepted. After that it may
  // leave a gap. Valid is not lowered when no gap follows, so back-to-back
  // requests keep it high.
  task automatic send_tick(input logic [PinW-1:0] pins);
    int unsigned gap;
    tick_bus.valid <= 1'b1;
    tick_bus.pin_levels <= pins;
    do @(posedge clk); while (!tick_bus.ready);
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      tick_bus.pin_levels <= PinW'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering ticks and waits until every queued result has come back,
  // and then a little longer. The first edge lets the monitor record a tick
  // that was accepted at the current one.
  task automatic drain();
    tick_bus.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Writes all six registers. Mask writes get random upper bits, which the
  // block must drop. With spare set, the two unused indexes are written too.
  task automatic configure(input logic [DelayW-1:0] d0, input logic [DelayW-1:0] d1,
                           input logic [DelayW-1:0] d2, input logic [DelayW-1:0] d3,
                           input logic [MaskW-1:0] high_mask,
                           input logic [MaskW-1:0] en_mask, input bit spare);
    logic [CfgDataW-1:0] word;
    cfg_write(REG_DELAY0, d0);
    cfg_write(REG_DELAY1, d1);
    cfg_write(REG_DELAY2, d2);
    cfg_write(REG_DELAY3, d3);
    word = CfgDataW'($urandom);
    word[MaskW-1:0] = high_mask;
    cfg_write(REG_ACTIVE_HIGH, word);
    if (spare) begin
      cfg_write(RegSpareA, CfgDataW'($urandom));
      cfg_write(RegSpareB, '1);
    end
    word = CfgDataW'($urandom);
    word[MaskW-1:0] = en_mask;
    cfg_write(REG_ENABLE, word);
    cfg_we <= 1'b0;
  endtask

  // One random phase. Each pin holds its level for a run of 1 to 10 ticks
  // and then flips, which gives presses of random length. One tick in seven
  // is pure noise instead. Sometimes the sender waits for all results first.
  task automatic random_phase(input int ticks_total);
    logic [PinW-1:0] pins;
    for (int i = 0; i < ticks_total; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 2) drain();
      if ($urandom_range(0, 6) == 0) begin
        pins = PinW'($urandom);
      end else begin
        for (int c = 0; c < HwChannels; c++) begin
          if (run_left[c] == 0) begin
            run_level[c] = ~run_level[c];
            run_left[c] = $urandom_range(1, 10);
          end
          run_left[c]--;
        end
        pins = run_level;
      end
      send_tick(pins);
    end
  endtask

  initial begin
    logic [MaskW-1:0] high_mask;
    logic [MaskW-1:0] en_mask;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.pin_levels <= '0;
    run_level = '0;
    for (int c = 0; c < HwChannels; c++) run_left[c] = 0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Right after reset every channel is disabled. Nothing may be reported,
    // whatever the pins do.
    send_tick(4'b0000);
    send_tick(4'b1111);
    drain();

    // Channel 0 uses press/release mode. Channels 1 to 3 use thresholds of
    // one, three and 0xFFFF ticks.
    configure(16'h0000, 16'h0001, 16'h0003, 16'hFFFF, 4'b0101, 4'b1111, 1'b0);
    foreach (PressScript[i]) send_tick(PressScript[i]);
    drain();

    // Channels 0 and 3 are now disabled. Channel 3 is halfway through a
    // press and must keep its count until it is enabled again.
    configure(16'h0000, 16'h0000, 16'h0002, 16'h0001, 4'b1111, 4'b0110, 1'b1);
    foreach (MaskScript[i]) send_tick(MaskScript[i]);
    drain();

    // Random phases. The first has every channel enabled and all pins active
    // low. The second has every channel enabled and all pins active high.
    // The rest use random masks.
    for (int p = 0; p < RandomPhases; p++) begin
      high_mask = (p == 0) ? 4'b0000 : (p == 1) ? 4'b1111 : MaskW'($urandom);
      en_mask = (p < 2) ? 4'b1111 : MaskW'($urandom);
      configure(pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                high_mask, en_mask, $urandom_range(0, 1));
      random_phase(PhaseTicks);
      drain();
    end

    for (int i = 0; i < board.outstanding(); i++) board.flag("result never arrived");
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("FAILURE");
    $finish;
  end

endmodule
